// ===== src/bmirq_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the bank mapper with scanline interrupt.
// No dependencies; every other file imports this package.
package bmirq_pkg;

	localparam int unsigned PATTERN_SLOTS = 8;
	localparam int unsigned SLOT_W = $clog2(PATTERN_SLOTS);

	localparam int unsigned CMD_W = 2;
	localparam int unsigned ADDR_W = 16;
	localparam int unsigned DATA_W = 8;
	localparam int unsigned MAP_W = 22;
	localparam int unsigned TICK_W = 10;
	localparam int unsigned COUNT_W = 16;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 10;

	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE    = 2'd0,
		CMD_TICK     = 2'd1,
		CMD_CPU_READ = 2'd2,
		CMD_PPU_READ = 2'd3
	} cmd_t;

	// Write port numbers above the pattern pages
	localparam logic [3:0] PORT_PRG_BANK = 4'd8;
	localparam logic [3:0] PORT_MIRROR   = 4'd9;
	localparam logic [3:0] PORT_IRQ_CTRL = 4'd10;
	localparam logic [3:0] PORT_LATCH_LO = 4'd11;
	localparam logic [3:0] PORT_LATCH_HI = 4'd12;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TICK_AMOUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LAST_PRG    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_ROM = 2'd2;

	localparam logic [TICK_W-1:0] TICK_AMOUNT_RST = 10'd114;
	localparam logic [DATA_W-1:0] LAST_PRG_RST = 8'd7;

	typedef struct packed {
		logic              fire;
		cmd_t              command;
		logic [ADDR_W-1:0] address;
		logic [DATA_W-1:0] value;
	} item_t;

	typedef struct packed {
		logic [PATTERN_SLOTS-1:0][DATA_W-1:0] pattern_page;
		logic [DATA_W-1:0]                    program_bank;
		logic [DATA_W-1:0]                    last_prg_bank;
		logic                                 pattern_rom_present;
	} bank_view_t;

	typedef struct packed {
		logic       irq_line;
		logic [1:0] mirroring;
	} status_t;

endpackage

// ===== src/bmirq_if.sv =====
`timescale 1ns / 1ps
// Handshake channels of the bank mapper: input items, result items and
// configuration writes. Depends on bmirq_pkg for field widths.
interface bmirq_req_if;
	import bmirq_pkg::*;
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [ADDR_W-1:0] address;
	logic [DATA_W-1:0] value;
	modport source (output valid, output command, output address, output value, input ready);
	modport sink (input valid, input command, input address, input value, output ready);
endinterface

interface bmirq_rsp_if;
	import bmirq_pkg::*;
	logic             valid;
	logic             ready;
	logic             irq_line;
	logic [1:0]       mirroring;
	logic             mapped_valid;
	logic [MAP_W-1:0] mapped_address;
	modport source (output valid, output irq_line, output mirroring, output mapped_valid,
		output mapped_address, input ready);
	modport sink (input valid, input irq_line, input mirroring, input mapped_valid,
		input mapped_address, output ready);
endinterface

interface bmirq_cfg_if;
	import bmirq_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/bank_mapper_with_scanline_irq.sv =====
`timescale 1ns / 1ps
// Bank mapper with scanline interrupt counter: one result item per input
// item, one item per cycle sustained while the output is not stalled. An
// accepted item sits in an input register while the mapper state updates
// and the result is computed, then waits in the output register. The rate
// is set by the single state update per cycle in the input stage.
// Configuration writes are taken at any time and take effect once they are
// registered. Depends on bmirq_pkg, the bmirq interfaces,
// bmirq_regs and bmirq_xlate.
module bank_mapper_with_scanline_irq (
	input  logic      clk,
	input  logic      arst_n,
	bmirq_req_if.sink req,
	bmirq_rsp_if.source rsp,
	bmirq_cfg_if.sink cfg
);
	import bmirq_pkg::*;

	logic              valid_s1;
	cmd_t              command_s1;
	logic [ADDR_W-1:0] address_s1;
	logic [DATA_W-1:0] value_s1;
	logic              out_valid_q;
	logic              advance;
	item_t             item;
	bank_view_t        view;
	status_t           status_next;
	logic              mapped_valid;
	logic [MAP_W-1:0]  mapped_address;

	assign advance = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	assign item.fire = advance;
	assign item.command = command_s1;
	assign item.address = address_s1;
	assign item.value = value_s1;

	bmirq_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.cfg         (cfg),
		.view        (view),
		.status_next (status_next)
	);

	bmirq_xlate u_xlate (
		.item           (item),
		.view           (view),
		.mapped_valid   (mapped_valid),
		.mapped_address (mapped_address)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			command_s1 <= cmd_t'(req.command);
			address_s1 <= req.address;
			value_s1 <= req.value;
		end
		if (advance) begin
			rsp.irq_line <= status_next.irq_line;
			rsp.mirroring <= status_next.mirroring;
			rsp.mapped_valid <= mapped_valid;
			rsp.mapped_address <= mapped_address;
		end
	end

	assign rsp.valid = out_valid_q;

endmodule

// ===== src/bmirq_regs.sv =====
`timescale 1ns / 1ps
// Bank, mirroring and interrupt counter registers plus configuration.
// Depends on bmirq_pkg and bmirq_cfg_if.
module bmirq_regs (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bmirq_pkg::item_t      item,
	bmirq_cfg_if.sink             cfg,
	output bmirq_pkg::bank_view_t view,
	output bmirq_pkg::status_t    status_next
);
	import bmirq_pkg::*;

	logic [PATTERN_SLOTS-1:0][DATA_W-1:0] page_q, page_d;
	logic [DATA_W-1:0]  prg_q, prg_d;
	logic [1:0]         mirror_q, mirror_d;
	logic [COUNT_W-1:0] latch_q, latch_d;
	logic [COUNT_W-1:0] count_q, count_d;
	logic               enabled_q, enabled_d;
	logic               raised_q, raised_d;
	logic [TICK_W-1:0]  tick_amount_q;
	logic [DATA_W-1:0]  last_prg_q;
	logic               pattern_rom_q;
	logic [3:0]         port;
	logic [COUNT_W-1:0] tick_ext;

	assign cfg.ready = 1'b1;
	assign port = item.address[3:0];
	assign tick_ext = {{(COUNT_W-TICK_W){1'b0}}, tick_amount_q};

	always_comb begin
		page_d = page_q;
		prg_d = prg_q;
		mirror_d = mirror_q;
		latch_d = latch_q;
		count_d = count_q;
		enabled_d = enabled_q;
		raised_d = raised_q;
		if (item.fire) begin
			case (item.command)
				CMD_WRITE: begin
					if (!port[3]) begin
						page_d[port[SLOT_W-1:0]] = item.value;
					end else begin
						case (port)
							PORT_PRG_BANK: prg_d = item.value;
							PORT_MIRROR:   mirror_d = item.value[1:0];
							PORT_IRQ_CTRL: begin
								raised_d = 1'b0;
								enabled_d = item.value[0];
								count_d = latch_q;
							end
							PORT_LATCH_LO: latch_d[7:0] = item.value;
							PORT_LATCH_HI: latch_d[15:8] = item.value;
							default: ;
						endcase
					end
				end
				CMD_TICK: begin
					if (enabled_q) begin
						// saturate at zero and raise the line
						if (count_q <= tick_ext) begin
							count_d = '0;
							enabled_d = 1'b0;
							raised_d = 1'b1;
						end else begin
							count_d = count_q - tick_ext;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PATTERN_SLOTS; i++) begin
				page_q[i] <= DATA_W'(i);
			end
			prg_q <= '0;
			mirror_q <= '0;
			latch_q <= '0;
			count_q <= '0;
			enabled_q <= 1'b0;
			raised_q <= 1'b0;
			tick_amount_q <= TICK_AMOUNT_RST;
			last_prg_q <= LAST_PRG_RST;
			pattern_rom_q <= 1'b1;
		end else begin
			page_q <= page_d;
			prg_q <= prg_d;
			mirror_q <= mirror_d;
			latch_q <= latch_d;
			count_q <= count_d;
			enabled_q <= enabled_d;
			raised_q <= raised_d;
			if (cfg.valid) begin
				case (cfg.index)
					CFG_TICK_AMOUNT: tick_amount_q <= cfg.data;
					CFG_LAST_PRG:    last_prg_q <= cfg.data[DATA_W-1:0];
					CFG_PATTERN_ROM: pattern_rom_q <= cfg.data[0];
					default: ;
				endcase
			end
		end
	end

	assign view.pattern_page = page_q;
	assign view.program_bank = prg_q;
	assign view.last_prg_bank = last_prg_q;
	assign view.pattern_rom_present = pattern_rom_q;
	assign status_next.irq_line = raised_d;
	assign status_next.mirroring = mirror_d;

endmodule

// ===== src/bmirq_xlate.sv =====
`timescale 1ns / 1ps
// Address translation of CPU and PPU bus accesses through the current banks.
// Depends on bmirq_pkg.
module bmirq_xlate (
	input  bmirq_pkg::item_t            item,
	input  bmirq_pkg::bank_view_t       view,
	output logic                        mapped_valid,
	output logic [bmirq_pkg::MAP_W-1:0] mapped_address
);
	import bmirq_pkg::*;

	logic [DATA_W-1:0] cpu_bank;
	logic [DATA_W-1:0] ppu_page;

	assign cpu_bank = item.address[14] ? view.last_prg_bank : view.program_bank;
	assign ppu_page = view.pattern_page[item.address[10 +: SLOT_W]];

	always_comb begin
		mapped_valid = 1'b0;
		mapped_address = '0;
		case (item.command)
			CMD_CPU_READ: begin
				if (item.address[15]) begin
					mapped_valid = 1'b1;
					mapped_address = {cpu_bank, item.address[13:0]};
				end
			end
			CMD_PPU_READ: begin
				if (item.address[15:13] == 3'b000 && view.pattern_rom_present) begin
					mapped_valid = 1'b1;
					mapped_address = MAP_W'({ppu_page, item.address[9:0]});
				end
			end
			default: ;
		endcase
	end

endmodule
